// ===== hdl/pab_pkg.sv =====
// Package for the pseudo-angle between test: constants and the lane control type.
// No dependencies.
package pab_pkg;
  localparam int CoordWidthDef = 16;
  localparam int FracBitsDef   = 16;

  localparam logic [1:0] REL_EQUAL   = 2'd0;
  localparam logic [1:0] REL_BETWEEN = 2'd1;
  localparam logic [1:0] REL_OUTSIDE = 2'd2;

  // Octant selection carried down the lane pipeline.
  typedef struct packed {
    logic       zero;
    logic       neg;   // angle = base - q
    logic [2:0] base;  // base in units of S (mod 8)
  } lane_ctl_t;
endpackage

// ===== hdl/pab_lane.sv =====
// One lane: octant pseudo-angle of one vector, with a pipelined restoring divider
// (one quotient bit per stage). Depends on pab_pkg.
module pab_lane #(
  parameter int CW = pab_pkg::CoordWidthDef,
  parameter int FB = pab_pkg::FracBitsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic signed [CW-1:0]      in_x,
  input  logic signed [CW-1:0]      in_y,
  output logic                      out_vld,
  output logic [FB+2:0]             out_ang,
  output logic                      out_zero
);
  import pab_pkg::*;

  localparam int MW = CW + 1;
  localparam int NS = FB;

  logic [MW-1:0] a, b, num, den, rem0;
  lane_ctl_t     ctl;
  logic          xp, yp, ge0;

  always_comb begin
    xp = ($signed(in_x) > 0);
    yp = ($signed(in_y) > 0);
    a  = in_x[CW-1] ? MW'(-{in_x[CW-1], in_x}) : MW'({1'b0, in_x});
    b  = in_y[CW-1] ? MW'(-{in_y[CW-1], in_y}) : MW'({1'b0, in_y});
    ctl.zero = (a == '0) && (b == '0);
    ctl.neg  = 1'b0;
    ctl.base = 3'd0;
    num = a;
    den = b;
    if (xp && yp) begin
      if (a > b) begin ctl.base = 3'd0; num = b; den = a; end
      else begin ctl.base = 3'd2; ctl.neg = 1'b1; end
    end else if (xp) begin
      if (a > b) begin ctl.base = 3'd0; ctl.neg = 1'b1; num = b; den = a; end
      else ctl.base = 3'd6;
    end else if (yp) begin
      if (a > b) begin ctl.base = 3'd4; ctl.neg = 1'b1; num = b; den = a; end
      else ctl.base = 3'd2;
    end else begin
      if (a < b) begin ctl.base = 3'd6; ctl.neg = 1'b1; end
      else begin ctl.base = 3'd4; num = b; den = a; end
    end
    // Integer quotient bit: set only when n == d.
    ge0  = (den != '0) && (num >= den);
    rem0 = ge0 ? (num - den) : num;
  end

  // Stage s holds partial remainder, divisor and quotient bits so far.
  logic          vld_r [NS+1];
  logic [MW:0]   rem_r [NS+1];
  logic [MW-1:0] den_r [NS+1];
  logic [FB:0]   q_r   [NS+1];
  lane_ctl_t     ctl_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_vld;
    rem_r[0] <= {1'b0, rem0};
    den_r[0] <= den;
    q_r[0]   <= {{FB{1'b0}}, ge0};
    ctl_r[0] <= ctl;
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [MW+1:0] sh;
    logic          ge;
    always_comb begin
      sh = {rem_r[s], 1'b0};
      ge = (den_r[s] != '0) && (sh >= {2'b00, den_r[s]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s+1] <= 1'b0;
      else vld_r[s+1] <= vld_r[s];
      rem_r[s+1] <= ge ? (MW+1)'(sh - {2'b00, den_r[s]}) : (MW+1)'(sh);
      den_r[s+1] <= den_r[s];
      q_r[s+1]   <= {q_r[s][FB-1:0], ge};
      ctl_r[s+1] <= ctl_r[s];
    end
  end

  logic [FB+2:0] basev, qv, ang_nxt, ang_r;
  logic          zero_r, ovld_r;
  always_comb begin
    basev = {ctl_r[NS].base, {FB{1'b0}}};
    // Quotient is at most S (n == d), which needs FB+1 bits.
    qv = {2'b00, q_r[NS]};
    ang_nxt = ctl_r[NS].neg ? (basev - qv) : (basev + qv);
    if (ctl_r[NS].zero) ang_nxt = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else ovld_r <= vld_r[NS];
    ang_r  <= ang_nxt;
    zero_r <= ctl_r[NS].zero;
  end
  assign out_vld  = ovld_r;
  assign out_ang  = ang_r;
  assign out_zero = zero_r;
endmodule

// ===== hdl/pab_merge.sv =====
// Merge stage: compares the three lane angles and forms relation and zero flag.
// Depends on pab_pkg.
module pab_merge #(
  parameter int FB = pab_pkg::FracBitsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [FB+2:0] ang_u,
  input  logic [FB+2:0] ang_v,
  input  logic [FB+2:0] ang_w,
  input  logic          zero_any,
  output logic          out_vld,
  output logic [1:0]    out_rel,
  output logic          out_zero
);
  import pab_pkg::*;

  logic [1:0] rel_nxt, rel_r;
  logic       vld_r, zero_r;

  always_comb begin
    if (ang_u == ang_v) rel_nxt = REL_EQUAL;
    else if ((ang_w >= ang_u && ang_w <= ang_v) || (ang_w <= ang_u && ang_w >= ang_v))
      rel_nxt = REL_BETWEEN;
    else rel_nxt = REL_OUTSIDE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
    rel_r  <= rel_nxt;
    zero_r <= zero_any;
  end
  assign out_vld  = vld_r;
  assign out_rel  = rel_r;
  assign out_zero = zero_r;

  a_rel_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (rel_r != 2'd3)) else $error("relation out of range");
  a_vld_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |=> vld_r) else $error("merge valid lost");
  a_eq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld && ang_u == ang_v) |=> (rel_r == REL_EQUAL)) else $error("equal angles missed");
endmodule

// ===== hdl/pseudo_angle_between_test.sv =====
// Top level of the pseudo-angle between test: three angle lanes and a merge stage.
// Depends on pab_pkg, pab_lane, pab_merge.
//
//  channel  ports                          handshake
//  input    in_ux..in_wy                   start & !busy
//  result   out_relation, out_zero_vector  out_valid strobe, one cycle
//
// One item per cycle; busy is always low. Each lane registers its input, then
// one quotient bit per divider stage, then the angle; merge registers the result.
// rst_n clears all valid bits synchronously; payload registers are not reset.
// The receiver cannot stall, so nothing is held back.
module pseudo_angle_between_test #(
  parameter int COORD_WIDTH = pab_pkg::CoordWidthDef,
  parameter int FRAC_BITS   = pab_pkg::FracBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_ux,
  input  logic signed [COORD_WIDTH-1:0] in_uy,
  input  logic signed [COORD_WIDTH-1:0] in_vx,
  input  logic signed [COORD_WIDTH-1:0] in_vy,
  input  logic signed [COORD_WIDTH-1:0] in_wx,
  input  logic signed [COORD_WIDTH-1:0] in_wy,
  output logic                          out_valid,
  output logic [1:0]                    out_relation,
  output logic                          out_zero_vector
);
  import pab_pkg::*;

  logic                 acc;
  logic [2:0]           lv, lz;
  logic [FRAC_BITS+2:0] au, av, aw;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  pab_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_lane_u (
    .clk, .rst_n, .in_vld(acc), .in_x(in_ux), .in_y(in_uy),
    .out_vld(lv[0]), .out_ang(au), .out_zero(lz[0]));
  pab_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_lane_v (
    .clk, .rst_n, .in_vld(acc), .in_x(in_vx), .in_y(in_vy),
    .out_vld(lv[1]), .out_ang(av), .out_zero(lz[1]));
  pab_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_lane_w (
    .clk, .rst_n, .in_vld(acc), .in_x(in_wx), .in_y(in_wy),
    .out_vld(lv[2]), .out_ang(aw), .out_zero(lz[2]));

  pab_merge #(.FB(FRAC_BITS)) u_merge (
    .clk, .rst_n, .in_vld(lv[0]), .ang_u(au), .ang_v(av), .ang_w(aw),
    .zero_any(|lz), .out_vld(out_valid), .out_rel(out_relation),
    .out_zero(out_zero_vector));

  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (lv[0] == lv[1]) && (lv[1] == lv[2])) else $error("lanes out of step");
  a_angle_u: assert property (@(posedge clk) disable iff (!rst_n)
    (lv[0] && lz[0]) |-> (au == '0)) else $error("zero vector angle not zero");
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");
endmodule

// ===== bench/tb_pseudo_angle_between_test.sv =====
// Testbench for pseudo_angle_between_test: directed table, then random vector triples in bursts.
// Results are checked against a local octant pseudo-angle predictor, in order.
// Depends on pab_pkg and the pseudo_angle_between_test RTL.
module tb_pseudo_angle_between_test;
  import pab_pkg::*;

  localparam int CW = CoordWidthDef;
  localparam int FB = FracBitsDef;
  localparam int LAT = FB + 3;
  localparam int N_RANDOM = 900;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t c[6];
    logic   has_exp;
    logic [1:0] rel;
    logic   zv;
  } triple_row_t;

  typedef struct {
    logic [1:0] rel;
    logic       zv;
  } relation_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_ux = '0, in_uy = '0, in_vx = '0, in_vy = '0, in_wx = '0, in_wy = '0;
  logic out_valid;
  logic [1:0] out_relation;
  logic out_zero_vector;

  relation_t pending_relations[$];
  int errors = 0;
  int idle_cycles = 0;

  pseudo_angle_between_test #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ux(in_ux), .in_uy(in_uy), .in_vx(in_vx), .in_vy(in_vy),
    .in_wx(in_wx), .in_wy(in_wy),
    .out_valid(out_valid), .out_relation(out_relation), .out_zero_vector(out_zero_vector)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [FB+2:0] octant_of(input coord_t x, input coord_t y, inout logic zero);
    logic [63:0] one, a, b, ang, lo, hi, q;
    one = 64'd1 << FB;
    a = (x < 0) ? 64'(-longint'(x)) : 64'(x);
    b = (y < 0) ? 64'(-longint'(y)) : 64'(y);
    if (a == 0 && b == 0) begin
      zero = 1'b1;
      return '0;
    end
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    q = (lo << FB) / hi;
    if (x > 0) begin
      if (y > 0) ang = (a > b) ? q : 2 * one - q;
      else ang = (a > b) ? 8 * one - q : 6 * one + q;
    end else begin
      if (y > 0) ang = (a > b) ? 4 * one - q : 2 * one + q;
      else ang = (a < b) ? 6 * one - q : 4 * one + q;
    end
    return ang[FB+2:0];
  endfunction

  function automatic relation_t predict_relation(input coord_t c[6]);
    relation_t r;
    logic zero;
    logic [FB+2:0] au, av, aw;
    zero = 1'b0;
    au = octant_of(c[0], c[1], zero);
    av = octant_of(c[2], c[3], zero);
    aw = octant_of(c[4], c[5], zero);
    if (au == av) r.rel = REL_EQUAL;
    else if ((aw >= au && aw <= av) || (aw <= au && aw >= av)) r.rel = REL_BETWEEN;
    else r.rel = REL_OUTSIDE;
    r.zv = zero;
    return r;
  endfunction

  // drives one item and holds until accepted
  task automatic send_triple(input coord_t c[6]);
    start <= 1'b1;
    in_ux <= c[0]; in_uy <= c[1]; in_vx <= c[2];
    in_vy <= c[3]; in_wx <= c[4]; in_wy <= c[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_relations.push_back(predict_relation(c));
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 6)) - 3;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return coord_t'($urandom_range(0, 255)) - 128;
      default: return coord_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_relations.size() == 0) begin
        $display("%0t: unexpected item rel=%0d zv=%0b", $time, out_relation, out_zero_vector);
        errors++;
      end else begin
        relation_t e;
        e = pending_relations.pop_front();
        if (out_relation !== e.rel) begin
          $display("%0t: relation expected %0d actual %0d", $time, e.rel, out_relation);
          errors++;
        end
        if (out_zero_vector !== e.zv) begin
          $display("%0t: zero_vector expected %0b actual %0b", $time, e.zv, out_zero_vector);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_pseudo_angle_between_test NOT OK");
      $finish;
    end
  end

  triple_row_t directed[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, REL_EQUAL, 1'b1},
    '{'{16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd5, 16'sd5}, 1'b1, REL_EQUAL, 1'b0},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1}, 1'b1, REL_BETWEEN, 1'b0},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd0}, 1'b1, REL_OUTSIDE, 1'b0},
    '{'{16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, REL_BETWEEN, 1'b1},
    '{'{-16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 16'sd0}, 1'b1, REL_OUTSIDE, 1'b0},
    '{'{16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd0}, 1'b0, 2'd0, 1'b0},
    '{'{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, 2'd0, 1'b0},
    '{'{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, 2'd0, 1'b0},
    '{'{16'sh8000, 16'sd0, 16'sd0, 16'sh8000, -16'sd1, -16'sd1}, 1'b0, 2'd0, 1'b0},
    '{'{16'sd1, -16'sd1, 16'sd2, -16'sd1, 16'sd1, -16'sd2}, 1'b0, 2'd0, 1'b0},
    '{'{-16'sd2, 16'sd1, -16'sd1, 16'sd2, -16'sd3, 16'sd1}, 1'b0, 2'd0, 1'b0},
    '{'{16'sh7fff, 16'sd1, 16'sd1, 16'sh7fff, 16'sh5555, 16'shaaaa}, 1'b0, 2'd0, 1'b0},
    '{'{-16'sd5, -16'sd3, -16'sd3, -16'sd5, -16'sd4, -16'sd4}, 1'b0, 2'd0, 1'b0}
  };

  initial begin
    coord_t c[6];
    relation_t p;
    int sent;
    int burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].has_exp) begin
        p = predict_relation(directed[i].c);
        if (p.rel !== directed[i].rel || p.zv !== directed[i].zv) begin
          $display("%0t: table row %0d expected %0d/%0b actual predictor %0d/%0b",
                   $time, i, directed[i].rel, directed[i].zv, p.rel, p.zv);
          errors++;
        end
      end
      send_triple(directed[i].c);
    end
    start <= 1'b0;
    // hold off until the pipe drains
    while (pending_relations.size() != 0) @(posedge clk);
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        foreach (c[j]) c[j] = rand_coord();
        if ($urandom_range(0, 15) == 0) begin
          c[$urandom_range(0, 2) * 2] = '0;
          c[$urandom_range(0, 2) * 2 + 1] = '0;
        end
        if ($urandom_range(0, 7) == 0) begin
          c[2] = c[0];
          c[3] = c[1];
        end
        send_triple(c);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, LAT + 4)) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending_relations.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    if (errors == 0) $display("tb_pseudo_angle_between_test OK");
    else $display("tb_pseudo_angle_between_test NOT OK");
    $finish;
  end
endmodule
